// ===== src/size_limited_label_propagation_assert.svh =====
`ifndef SIZE_LIMITED_LABEL_PROPAGATION_ASSERT_SVH
`define SIZE_LIMITED_LABEL_PROPAGATION_ASSERT_SVH
// property that must hold in the same cycle
`define SLLP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sllp check failed");
// property that must hold in the following cycle
`define SLLP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sllp check failed");
`endif

// ===== src/sllp_pkg.sv =====
`timescale 1ns / 1ps
package sllp_pkg;

    localparam int ID_W           = 12;
    localparam int SIZE_W         = 13;
    localparam int CNT_W          = 7;
    localparam int CNT_MAX        = 127;
    localparam int LIMIT_RESET    = 64;
    localparam int VERTICES_DEF   = 4096;
    localparam int MAX_DEGREE_DEF = 64;

    typedef struct packed {
        logic [ID_W-1:0] vertex;
        logic [ID_W-1:0] neighbor;
        logic            edge_valid;
        logic            last;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]  out_vertex;
        logic [ID_W-1:0]  chosen_cluster;
        logic             moved;
        logic [CNT_W-1:0] best_hits;
    } t_res;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_RD_NBR,
        OP_RD_CNT,
        OP_EDGE_WR,
        OP_RD_OWN,
        OP_OWN_CNT,
        OP_OWN_LATCH,
        OP_RD_TOUCH,
        OP_SCAN_CNT,
        OP_SCAN_CMP,
        OP_UPD_OWN,
        OP_UPD_BEST,
        OP_CLR_RD,
        OP_CLR_WR,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic tlen_zero;
        logic scan_last;
        logic req_last;
    } t_sts;

    // restoring reduction of an id by the vertex count
    function automatic logic [ID_W-1:0] id_reduce(input logic [ID_W-1:0] x,
                                                  input int unsigned m);
        logic [31:0] xw;
        xw = 32'(x);
        for (int k = ID_W - 1; k >= 0; k--) begin
            if (xw >= (32'(m) << k)) begin
                xw = xw - (32'(m) << k);
            end
        end
        return xw[ID_W-1:0];
    endfunction

endpackage

// ===== src/sllp_ctrl.sv =====
`timescale 1ns / 1ps
module sllp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  sllp_pkg::t_req i_req,
    input  sllp_pkg::t_sts i_sts,
    output sllp_pkg::t_cmd o_cmd,
    output logic          busy
);
    import sllp_pkg::*;

    typedef enum logic [15:0] {
        S_CLEAR = 16'h0001,
        S_IDLE  = 16'h0002,
        S_ELBL  = 16'h0004,
        S_ECNT  = 16'h0008,
        S_EWR   = 16'h0010,
        S_DOWN  = 16'h0020,
        S_DOWNC = 16'h0040,
        S_DOWNR = 16'h0080,
        S_SRD   = 16'h0100,
        S_SCNT  = 16'h0200,
        S_SCMP  = 16'h0400,
        S_UPD   = 16'h0800,
        S_UPD2  = 16'h1000,
        S_CRD   = 16'h2000,
        S_CWR   = 16'h4000,
        S_OUT   = 16'h8000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = OP_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_INIT;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_LOAD;
                    if (i_req.edge_valid) n_state = S_ELBL;
                    else if (i_req.last) n_state = S_DOWN;
                end
            end
            S_ELBL: begin o_cmd.op = OP_RD_NBR;  n_state = S_ECNT; end
            S_ECNT: begin o_cmd.op = OP_RD_CNT;  n_state = S_EWR;  end
            S_EWR: begin
                o_cmd.op = OP_EDGE_WR;
                n_state  = i_sts.req_last ? S_DOWN : S_IDLE;
            end
            S_DOWN:  begin o_cmd.op = OP_RD_OWN; n_state = S_DOWNC; end
            S_DOWNC: begin o_cmd.op = OP_OWN_CNT; n_state = S_DOWNR; end
            S_DOWNR: begin
                o_cmd.op = OP_OWN_LATCH;
                n_state  = i_sts.tlen_zero ? S_UPD : S_SRD;
            end
            S_SRD:  begin o_cmd.op = OP_RD_TOUCH; n_state = S_SCNT; end
            S_SCNT: begin o_cmd.op = OP_SCAN_CNT; n_state = S_SCMP; end
            S_SCMP: begin
                o_cmd.op = OP_SCAN_CMP;
                n_state  = i_sts.scan_last ? S_UPD : S_SRD;
            end
            S_UPD: begin o_cmd.op = OP_UPD_OWN; n_state = S_UPD2; end
            S_UPD2: begin
                o_cmd.op = OP_UPD_BEST;
                n_state  = i_sts.tlen_zero ? S_OUT : S_CRD;
            end
            S_CRD: begin o_cmd.op = OP_CLR_RD; n_state = S_CWR; end
            S_CWR: begin
                o_cmd.op = OP_CLR_WR;
                n_state  = i_sts.scan_last ? S_OUT : S_CRD;
            end
            S_OUT: begin o_cmd.op = OP_EMIT; n_state = S_IDLE; end
            default: n_state = S_CLEAR;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== src/sllp_datapath.sv =====
`timescale 1ns / 1ps
module sllp_datapath #(
    parameter int VERTICES   = sllp_pkg::VERTICES_DEF,
    parameter int MAX_DEGREE = sllp_pkg::MAX_DEGREE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sllp_pkg::t_req                i_req,
    input  sllp_pkg::t_cmd                i_cmd,
    input  logic                          i_cfg_valid,
    input  logic [sllp_pkg::SIZE_W-1:0]   i_cfg_data,
    output sllp_pkg::t_sts                o_sts,
    output sllp_pkg::t_res                o_res,
    output logic                          o_res_strobe
);
    import sllp_pkg::*;

    localparam int IDX_W = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int TI_W  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int TL_W  = $clog2(MAX_DEGREE + 1);

    logic [IDX_W-1:0]  label_mem [VERTICES];
    logic [SIZE_W-1:0] size_mem  [VERTICES];
    logic [CNT_W-1:0]  count_mem [VERTICES];
    logic [IDX_W-1:0]  touch_mem [MAX_DEGREE];

    logic [IDX_W-1:0]  r_label_q, r_touch_q;
    logic [SIZE_W-1:0] r_size_q;
    logic [CNT_W-1:0]  r_cnt_q;

    logic [IDX_W-1:0]  r_idx, r_vtx, r_nbr, r_c, r_own, r_best;
    logic              r_last;
    logic [CNT_W-1:0]  r_best_cnt;
    logic [SIZE_W-1:0] r_best_size, r_own_size, r_limit;
    logic [TL_W-1:0]   r_tlen;
    logic [TI_W-1:0]   r_scan;
    t_res              r_res;
    logic              r_strobe;

    logic [IDX_W-1:0]  label_raddr, count_raddr, size_raddr;
    logic              moved, tl_room, take;

    assign moved   = (r_best != r_own);
    assign tl_room = (r_tlen < TL_W'(MAX_DEGREE));

    always_comb begin
        label_raddr = (i_cmd.op == OP_RD_NBR) ? r_nbr : r_vtx;
        count_raddr = (i_cmd.op == OP_SCAN_CNT) ? r_touch_q : r_label_q;
        size_raddr  = (i_cmd.op == OP_SCAN_CNT) ? r_touch_q : r_label_q;
    end

    // candidate test of one touched cluster
    assign take = (r_c != r_own) && (r_size_q < r_limit) &&
                  ((r_cnt_q > r_best_cnt) ||
                   ((r_cnt_q == r_best_cnt) && (r_best != r_own) &&
                    (r_size_q < r_best_size)));

    // memories
    always_ff @(posedge i_clk) begin
        r_label_q <= label_mem[label_raddr];
        r_cnt_q   <= count_mem[count_raddr];
        r_size_q  <= size_mem[size_raddr];
        r_touch_q <= touch_mem[r_scan];
        case (i_cmd.op)
            OP_INIT: begin
                label_mem[r_idx] <= r_idx;
                size_mem[r_idx]  <= SIZE_W'(1);
                count_mem[r_idx] <= '0;
            end
            OP_EDGE_WR: begin
                if (r_cnt_q == '0) begin
                    if (tl_room) begin
                        count_mem[r_c]                 <= CNT_W'(1);
                        touch_mem[r_tlen[TI_W-1:0]]    <= r_c;
                    end
                end else if (r_cnt_q < CNT_W'(CNT_MAX)) begin
                    count_mem[r_c] <= r_cnt_q + CNT_W'(1);
                end
            end
            OP_UPD_OWN: begin
                if (moved) begin
                    label_mem[r_vtx] <= r_best;
                    size_mem[r_own]  <= (r_own_size != '0) ?
                                        r_own_size - SIZE_W'(1) : r_own_size;
                end
            end
            OP_UPD_BEST: begin
                if (moved) size_mem[r_best] <= r_best_size + SIZE_W'(1);
            end
            OP_CLR_WR: count_mem[r_touch_q] <= '0;
            default: ;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_vtx  <= IDX_W'(id_reduce(i_req.vertex, VERTICES));
                r_nbr  <= IDX_W'(id_reduce(i_req.neighbor, VERTICES));
                r_last <= i_req.last;
            end
            OP_RD_CNT: r_c <= r_label_q;
            OP_OWN_CNT: begin
                r_own  <= r_label_q;
                r_best <= r_label_q;
            end
            OP_OWN_LATCH: begin
                r_best_cnt  <= r_cnt_q;
                r_own_size  <= r_size_q;
                r_best_size <= r_size_q;
            end
            OP_SCAN_CNT: r_c <= r_touch_q;
            OP_SCAN_CMP: begin
                if (take) begin
                    r_best      <= r_c;
                    r_best_cnt  <= r_cnt_q;
                    r_best_size <= r_size_q;
                end
            end
            OP_EMIT: begin
                r_res.out_vertex     <= ID_W'(r_vtx);
                r_res.chosen_cluster <= ID_W'(r_best);
                r_res.moved          <= moved;
                r_res.best_hits      <= r_best_cnt;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_tlen   <= '0;
            r_scan   <= '0;
            r_strobe <= 1'b0;
            r_limit  <= SIZE_W'(LIMIT_RESET);
        end else begin
            r_strobe <= (i_cmd.op == OP_EMIT);
            if (i_cfg_valid) r_limit <= i_cfg_data;
            case (i_cmd.op)
                OP_INIT:     r_idx <= r_idx + IDX_W'(1);
                OP_EDGE_WR: begin
                    if (r_cnt_q == '0 && tl_room) r_tlen <= r_tlen + TL_W'(1);
                end
                OP_OWN_LATCH: r_scan <= '0;
                OP_UPD_BEST:  r_scan <= '0;
                OP_SCAN_CMP:  r_scan <= r_scan + TI_W'(1);
                OP_CLR_WR:    r_scan <= r_scan + TI_W'(1);
                OP_EMIT:      r_tlen <= '0;
                default: ;
            endcase
        end
    end

    assign o_sts.clr_last  = (r_idx == IDX_W'(VERTICES - 1));
    assign o_sts.tlen_zero = (r_tlen == '0);
    assign o_sts.scan_last = ((TL_W'(r_scan) + TL_W'(1)) == r_tlen);
    assign o_sts.req_last  = r_last;
    assign o_res           = r_res;
    assign o_res_strobe    = r_strobe;

endmodule

// ===== src/size_limited_label_propagation.sv =====
`timescale 1ns / 1ps
// edge request: busy through the neighbour label read, count read and count write, then the next request is taken
// last request: any edge steps, own read, scan per seen cluster, size update, clears, emit
// result strobe comes in the same cycle that busy falls, one cycle wide; receiver cannot stall
// throughput set by the single-port read-modify-write of the count memory per edge
// reset is synchronous; afterwards a clearing pass over all VERTICES entries holds busy high
module size_limited_label_propagation #(
    parameter int VERTICES   = sllp_pkg::VERTICES_DEF,
    parameter int MAX_DEGREE = sllp_pkg::MAX_DEGREE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  sllp_pkg::t_req              i_req,
    output sllp_pkg::t_res              o_res,
    output logic                        o_res_strobe,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [sllp_pkg::SIZE_W-1:0] i_cfg_data
);
    import sllp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // the size limit register always takes a write
    assign o_cfg_ready = 1'b1;

    // sequencer: walks reset clearing, edge update, decision scan, size update, count clearing and emit
    sllp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // label, size and count memories, touched list and the best-cluster registers
    sllp_datapath #(
        .VERTICES   (VERTICES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cmd        (cmd),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_sts        (sts),
        .o_res        (o_res),
        .o_res_strobe (o_res_strobe)
    );

endmodule

// ===== src/sllp_checker.sv =====
`timescale 1ns / 1ps
`include "size_limited_label_propagation_assert.svh"
module sllp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input sllp_pkg::t_req i_req,
    input logic           o_res_strobe
);
    `SLLP_ASSERT_NEXT(a_no_instant_result, start && !busy, !o_res_strobe)
    `SLLP_ASSERT_NEXT(a_work_sets_busy, start && !busy && (i_req.edge_valid || i_req.last), busy)
    `SLLP_ASSERT_NEXT(a_single_strobe, o_res_strobe, !o_res_strobe)
    `SLLP_ASSERT_NOW(a_result_when_idle, o_res_strobe, !busy)
endmodule

bind size_limited_label_propagation sllp_checker u_sllp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_req        (i_req),
    .o_res_strobe (o_res_strobe)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import sllp_pkg::*;

    localparam int NV = 4096;
    localparam int ND = 64;
    localparam int WATCHDOG_LIMIT = 200000;

    // cluster decision predictor with its own copy of the cluster state
    class cluster_scoreboard;
        logic [ID_W-1:0]   label_of [NV];
        logic [SIZE_W-1:0] size_of [NV];
        logic [CNT_W-1:0]  count_of [NV];
        logic [ID_W-1:0]   seen [ND];
        int                seen_len;
        logic [SIZE_W-1:0] limit;
        t_res              pending [$];
        int                errors;

        function void clear();
            for (int i = 0; i < NV; i++) begin
                label_of[i] = ID_W'(i);
                size_of[i] = 1;
                count_of[i] = 0;
            end
            seen_len = 0;
            limit = SIZE_W'(LIMIT_RESET);
            errors = 0;
        endfunction

        function void note_request(t_req r);
            logic [ID_W-1:0] c, own, best;
            logic [CNT_W-1:0] best_cnt;
            bit counted;
            t_res e;
            if (r.edge_valid) begin
                c = label_of[r.neighbor];
                counted = 1;
                if (count_of[c] == 0) begin
                    if (seen_len < ND) begin
                        seen[seen_len] = c;
                        seen_len++;
                    end else begin
                        counted = 0;
                    end
                end
                if (counted && count_of[c] < CNT_MAX) count_of[c]++;
            end
            if (!r.last) return;
            own = label_of[r.vertex];
            best = own;
            best_cnt = count_of[own];
            for (int i = 0; i < seen_len; i++) begin
                c = seen[i];
                if (c != own && size_of[c] < limit &&
                    (count_of[c] > best_cnt ||
                     (count_of[c] == best_cnt && best != own && size_of[c] < size_of[best])))
                begin
                    best = c;
                    best_cnt = count_of[c];
                end
            end
            if (best != own) begin
                if (size_of[own] > 0) size_of[own]--;
                size_of[best]++;
                label_of[r.vertex] = best;
            end
            for (int i = 0; i < seen_len; i++) count_of[seen[i]] = 0;
            seen_len = 0;
            e.out_vertex = r.vertex;
            e.chosen_cluster = best;
            e.moved = (best != own);
            e.best_hits = best_cnt;
            pending.insert(pending.size(), e);
        endfunction

        function void check_result(t_res got);
            t_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.out_vertex !== e.out_vertex || got.chosen_cluster !== e.chosen_cluster ||
                got.moved !== e.moved || got.best_hits !== e.best_hits) begin
                $display("%0t: mismatch, expected v=%0d c=%0d m=%0d n=%0d, %s",
                         $time, e.out_vertex, e.chosen_cluster, e.moved, e.best_hits,
                         $sformatf("actual v=%0d c=%0d m=%0d n=%0d",
                                   got.out_vertex, got.chosen_cluster, got.moved,
                                   got.best_hits));
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_req              i_req;
    t_res              o_res;
    logic              o_res_strobe;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_data;

    cluster_scoreboard sb;
    int                idle_pct;
    int                quiet_cycles;

    size_limited_label_propagation uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_res(o_res), .o_res_strobe(o_res_strobe),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // sample at rising edge: requests into the predictor, results against it
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_request(i_req);
            if (o_res_strobe) sb.check_result(o_res);
            if ((start && !busy) || o_res_strobe || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // one request, held until taken; random idle before it
    // start is left high on return and is replaced by the next request or dropped
    task automatic send_request(input t_req r);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 0;
            @(negedge i_clk);
        end
        start <= 1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic send_edge(input int v, input int nb, input bit ev, input bit lst);
        t_req r;
        r.vertex = ID_W'(v);
        r.neighbor = ID_W'(nb);
        r.edge_valid = ev;
        r.last = lst;
        send_request(r);
    endtask

    // write the limit only with the block drained
    task automatic write_limit(input int val);
        start <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (700) @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data <= SIZE_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.limit = SIZE_W'(val);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // vertex update with neighbours mostly drawn from a small pool
    task automatic random_vertex(input int pool);
        int v, deg;
        v = $urandom_range(pool - 1, 0);
        if ($urandom_range(9, 0) == 0) v = $urandom_range(NV - 1, 0);
        deg = $urandom_range(6, 0);
        if ($urandom_range(19, 0) == 0) deg = $urandom_range(90, 7);
        for (int k = 0; k < deg; k++)
            send_edge(v, ($urandom_range(9, 0) == 0) ? $urandom_range(NV - 1, 0)
                                                     : $urandom_range(pool - 1, 0),
                      1, 0);
        if ($urandom_range(5, 0) == 0) send_edge(v, $urandom_range(NV - 1, 0), 0, 1);
        else send_edge(v, $urandom_range(pool - 1, 0), 1, 1);
    endtask

    initial begin
        int limits [5];
        sb = new();
        sb.clear();
        limits = '{1, 4096, 3, 0, 8191};
        i_rst_n = 0;
        start = 0;
        i_req = '0;
        i_cfg_valid = 0;
        i_cfg_data = '0;
        idle_pct = 0;
        quiet_cycles = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: extremes, no-edge items, vertex change, saturation
        send_edge(0, 4095, 1, 0);
        send_edge(0, 4095, 1, 1);
        send_edge(4095, 0, 0, 1);
        send_edge(5, 6, 0, 0);
        send_edge(5, 6, 1, 0);
        send_edge(7, 6, 1, 1);
        for (int k = 0; k < 70; k++) send_edge(10, 20 + k, 1, 0);
        send_edge(10, 20, 1, 1);
        for (int k = 0; k < 130; k++) send_edge(11, 12, 1, 0);
        send_edge(11, 12, 1, 1);
        send_edge(30, 31, 1, 0);
        send_edge(30, 32, 1, 1);
        send_edge(2730, 1365, 1, 1);

        for (int ph = 0; ph < 5; ph++) begin
            write_limit(limits[ph]);
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 74;
                2: idle_pct = 20;
                default: idle_pct = $urandom_range(1, 0) ? 74 : 0;
            endcase
            for (int n = 0; n < 22; n++) random_vertex(ph == 4 ? 4096 : 24);
        end
        write_limit(64);

        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/sllp_pkg.sv
src/sllp_ctrl.sv
src/sllp_datapath.sv
src/size_limited_label_propagation.sv
src/sllp_checker.sv
tb/tb.sv
